// ===== src/teq_pkg.sv =====
// shared types, constants and helper functions for the timestamp ordered event queue
// used by teq_ctrl and timestamp_ordered_event_queue; no dependencies
package teq_pkg;

   // queue geometry
   localparam int QUEUE_DEPTH = 32;
   localparam int ADDR_W      = $clog2(QUEUE_DEPTH);
   localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
   localparam int PTR_W       = ADDR_W + 1;
   localparam int FILL_W      = 6;

   localparam logic [CNT_W-1:0] COUNT_FULL = CNT_W'(QUEUE_DEPTH);
   localparam logic [PTR_W-1:0] DEPTH_WRAP = PTR_W'(QUEUE_DEPTH);

   // stream word layout
   localparam int REQ_TDATA_W = 56;
   localparam int RSP_TDATA_W = 64;
   localparam int RSP_TUSER_W = 3;
   localparam int RSP_PAD_W   = RSP_TDATA_W - 62;

   // request kinds
   localparam logic REQ_INSERT = 1'b0;
   localparam logic REQ_POP    = 1'b1;

   // status codes
   localparam logic [1:0] STATUS_OK    = 2'd0;
   localparam logic [1:0] STATUS_FULL  = 2'd1;
   localparam logic [1:0] STATUS_EMPTY = 2'd2;

   typedef struct packed {
      logic [15:0]        payload;
      logic [7:0]         microstep;
      logic signed [31:0] timestamp;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

   typedef struct packed {
      logic [FILL_W-1:0] fill_count;
      entry_type         ent;
      logic              out_valid;
      logic [1:0]        status;
   } rsp_type;

   // true when a sorts strictly after b: signed timestamp, then microstep
   function automatic logic key_gt(input entry_type a, input entry_type b);
      logic [39:0] ka;
      logic [39:0] kb;
      ka = {~a.timestamp[31], a.timestamp[30:0], a.microstep};
      kb = {~b.timestamp[31], b.timestamp[30:0], b.microstep};
      return ka > kb;
   endfunction

   // physical slot of a logical position in the circular store
   function automatic logic [ADDR_W-1:0] phys_addr(input logic [ADDR_W-1:0] base,
                                                   input logic [ADDR_W-1:0] offs);
      logic [PTR_W-1:0] sum;
      sum = {1'b0, base} + {1'b0, offs};
      if (sum >= DEPTH_WRAP) begin
         sum = sum - DEPTH_WRAP;
      end
      return sum[ADDR_W-1:0];
   endfunction

endpackage

// ===== src/teq_ram.sv =====
// generic simple dual port ram, one write and one registered read per cycle
// no dependencies
module teq_ram #(
   parameter int DATA_W = 56,
   parameter int DEPTH  = 32,
   parameter int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [DATA_W-1:0] wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [DATA_W-1:0] rd_data
);

   logic [DATA_W-1:0] mem [DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== src/teq_ctrl.sv =====
// sequencer of the event queue: circular store in teq_ram, head cache, insertion scan
// depends on teq_pkg and teq_ram
module teq_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic               req_kind,
   input  teq_pkg::entry_type req_ent,
   output logic               ready,
   output logic               res_pend,
   output teq_pkg::rsp_type   res,
   input  logic               res_take
);

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_SCAN  = 2'd1;
   localparam logic [1:0] ST_PLACE = 2'd2;
   localparam logic [1:0] ST_POPLD = 2'd3;

   logic [1:0]                  state_ff, state_in;
   logic [teq_pkg::ADDR_W-1:0]  head_ptr_ff, head_ptr_in;
   logic [teq_pkg::CNT_W-1:0]   count_ff, count_in;
   logic [teq_pkg::ADDR_W-1:0]  cur_ff, cur_in;
   teq_pkg::entry_type          head_ent_ff, head_ent_in;
   teq_pkg::entry_type          new_ent_ff, new_ent_in;
   teq_pkg::rsp_type            res_ff, res_in;
   logic                        res_pend_ff, res_pend_in;

   logic                        wr_en;
   logic [teq_pkg::ADDR_W-1:0]  wr_addr;
   teq_pkg::entry_type          wr_ent;
   logic [teq_pkg::ADDR_W-1:0]  rd_addr;
   logic [teq_pkg::ENTRY_W-1:0] rd_data;
   teq_pkg::entry_type          rd_ent;
   teq_pkg::entry_type          ins_head;
   logic [teq_pkg::CNT_W-1:0]   count_dec;
   logic [teq_pkg::CNT_W-1:0]   count_inc;

   teq_ram #(
      .DATA_W (teq_pkg::ENTRY_W),
      .DEPTH  (teq_pkg::QUEUE_DEPTH),
      .ADDR_W (teq_pkg::ADDR_W)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_ent),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign rd_ent    = rd_data;
   assign count_dec = count_ff - 1'b1;
   assign count_inc = count_ff + 1'b1;
   // equal keys keep the older head
   assign ins_head  = teq_pkg::key_gt(head_ent_ff, req_ent) ? req_ent : head_ent_ff;

   always_comb begin
      state_in    = state_ff;
      head_ptr_in = head_ptr_ff;
      count_in    = count_ff;
      cur_in      = cur_ff;
      head_ent_in = head_ent_ff;
      new_ent_in  = new_ent_ff;
      res_in      = res_ff;
      res_pend_in = res_pend_ff;
      wr_en       = 1'b0;
      wr_addr     = teq_pkg::phys_addr(head_ptr_ff, cur_ff + 1'b1);
      wr_ent      = new_ent_ff;
      rd_addr     = teq_pkg::phys_addr(head_ptr_ff, cur_ff - 1'b1);

      if (res_take) begin
         res_pend_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               res_pend_in = 1'b1;
               res_in      = '0;
               if (req_kind == teq_pkg::REQ_INSERT) begin
                  if (count_ff == teq_pkg::COUNT_FULL) begin
                     res_in.status     = teq_pkg::STATUS_FULL;
                     res_in.out_valid  = 1'b1;
                     res_in.ent        = head_ent_ff;
                     res_in.fill_count = teq_pkg::FILL_W'(count_ff);
                  end else if (count_ff == '0) begin
                     wr_en             = 1'b1;
                     wr_addr           = head_ptr_ff;
                     wr_ent            = req_ent;
                     head_ent_in       = req_ent;
                     count_in          = count_inc;
                     res_in.status     = teq_pkg::STATUS_OK;
                     res_in.out_valid  = 1'b1;
                     res_in.ent        = req_ent;
                     res_in.fill_count = teq_pkg::FILL_W'(count_inc);
                  end else begin
                     // start the scan at the tail entry
                     new_ent_in        = req_ent;
                     cur_in            = count_dec[teq_pkg::ADDR_W-1:0];
                     rd_addr           = teq_pkg::phys_addr(head_ptr_ff,
                                                            count_dec[teq_pkg::ADDR_W-1:0]);
                     head_ent_in       = ins_head;
                     count_in          = count_inc;
                     state_in          = ST_SCAN;
                     res_in.status     = teq_pkg::STATUS_OK;
                     res_in.out_valid  = 1'b1;
                     res_in.ent        = ins_head;
                     res_in.fill_count = teq_pkg::FILL_W'(count_inc);
                  end
               end else begin
                  if (count_ff == '0) begin
                     res_in.status     = teq_pkg::STATUS_EMPTY;
                     res_in.fill_count = teq_pkg::FILL_W'(count_ff);
                  end else begin
                     res_in.status     = teq_pkg::STATUS_OK;
                     res_in.out_valid  = 1'b1;
                     res_in.ent        = head_ent_ff;
                     res_in.fill_count = teq_pkg::FILL_W'(count_dec);
                     count_in          = count_dec;
                     head_ptr_in       = teq_pkg::phys_addr(head_ptr_ff,
                                                            teq_pkg::ADDR_W'(1));
                     // fetch the next head into the cache
                     rd_addr           = teq_pkg::phys_addr(head_ptr_ff,
                                                            teq_pkg::ADDR_W'(1));
                     if (count_dec != '0) begin
                        state_in = ST_POPLD;
                     end
                  end
               end
            end
         end

         ST_SCAN: begin
            if (teq_pkg::key_gt(rd_ent, new_ent_ff)) begin
               // move the larger entry up one slot
               wr_en  = 1'b1;
               wr_ent = rd_ent;
               if (cur_ff == '0) begin
                  state_in = ST_PLACE;
               end else begin
                  cur_in = cur_ff - 1'b1;
               end
            end else begin
               wr_en    = 1'b1;
               wr_ent   = new_ent_ff;
               state_in = ST_IDLE;
            end
         end

         ST_PLACE: begin
            wr_en    = 1'b1;
            wr_addr  = head_ptr_ff;
            wr_ent   = new_ent_ff;
            state_in = ST_IDLE;
         end

         ST_POPLD: begin
            head_ent_in = rd_ent;
            state_in    = ST_IDLE;
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         head_ptr_ff <= '0;
         count_ff    <= '0;
         res_pend_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         head_ptr_ff <= head_ptr_in;
         count_ff    <= count_in;
         res_pend_ff <= res_pend_in;
      end
      cur_ff      <= cur_in;
      head_ent_ff <= head_ent_in;
      new_ent_ff  <= new_ent_in;
      res_ff      <= res_in;
   end

   assign ready    = (state_ff == ST_IDLE) && !res_pend_ff;
   assign res_pend = res_pend_ff;
   assign res      = res_ff;

endmodule

// ===== src/timestamp_ordered_event_queue.sv =====
// top level of the timestamp ordered event queue: stream ports and output word register
// depends on teq_pkg and teq_ctrl
// a response word passes through the sequencer's result register and then the output word register
// a new request is taken only once the previous one is done and its result has moved on; an insert
// into a non-empty, non-full store first moves each stored entry that sorts after the new event, one move per cycle
// reset clears count, head pointer, sequencer state and handshake state; the entry ram itself is not cleared
module timestamp_ordered_event_queue (
   input  logic                            clock,
   input  logic                            reset,
   // request stream
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // ev_timestamp[31:0], ev_microstep[39:32], ev_payload[55:40]
   input  logic [teq_pkg::REQ_TDATA_W-1:0] req_tdata,
   // req_type[0]: insert or pop
   input  logic                            req_tuser,
   // response stream
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // out_timestamp[31:0], out_microstep[39:32], out_payload[55:40], fill_count[61:56]
   output logic [teq_pkg::RSP_TDATA_W-1:0] rsp_tdata,
   // status[1:0], out_valid[2]
   output logic [teq_pkg::RSP_TUSER_W-1:0] rsp_tuser
);

   teq_pkg::entry_type req_ent;
   logic               start;
   logic               ctl_ready;
   logic               res_pend;
   teq_pkg::rsp_type   res;
   logic               res_take;

   // output word register
   logic               rsp_valid_ff, rsp_valid_in;
   teq_pkg::rsp_type   rsp_ff, rsp_in;

   // unpack the request word
   assign req_ent.timestamp = req_tdata[31:0];
   assign req_ent.microstep = req_tdata[39:32];
   assign req_ent.payload   = req_tdata[55:40];

   // a request is taken only while the sequencer is idle and its result slot is free
   assign req_tready = ctl_ready;
   assign start      = req_tvalid && ctl_ready;

   teq_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .req_kind (req_tuser),
      .req_ent  (req_ent),
      .ready    (ctl_ready),
      .res_pend (res_pend),
      .res      (res),
      .res_take (res_take)
   );

   // move a finished result into the output register when it is empty or draining
   assign res_take = res_pend && (!rsp_valid_ff || rsp_tready);

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      if (res_take) begin
         rsp_valid_in = 1'b1;
         rsp_in       = res;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_ff <= rsp_in;
   end

   // pack the response word
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{teq_pkg::RSP_PAD_W{1'b0}}, rsp_ff.fill_count, rsp_ff.ent.payload,
                        rsp_ff.ent.microstep, rsp_ff.ent.timestamp};
   assign rsp_tuser  = {rsp_ff.out_valid, rsp_ff.status};

endmodule
